### src/mce_pkg.sv
// ----------------------------------------------------------------------------
// mce_pkg: shared types and constants for the Matern covariance evaluator
// Holds the sequencer states, register indexes, kernel codes and the
// fixed-point constants of the kernel arithmetic.
// ----------------------------------------------------------------------------
package mce_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_KERNEL_KIND   = 2'd0;
  localparam logic [1:0] REG_INV_LENGTH    = 2'd1;
  localparam logic [1:0] REG_SIGNAL_VAR    = 2'd2;

  // Kernel selector codes
  localparam logic [1:0] KIND_HALF         = 2'd0;
  localparam logic [1:0] KIND_THREE_HALVES = 2'd1;
  localparam logic [1:0] KIND_FIVE_HALVES  = 2'd2;

  // Fixed-point constants
  localparam logic [31:0] SQRT3_Q16       = 32'd113512;
  localparam logic [31:0] SQRT5_Q16       = 32'd146543;
  localparam logic [31:0] FIVE_THIRDS_Q16 = 32'd109227;
  localparam logic [31:0] LOG2E_Q30       = 32'd1549082005;
  localparam logic [31:0] LN2_Q30         = 32'd744261118;
  localparam logic [63:0] RND_Q16         = 64'h8000;
  localparam logic [63:0] RND_Q30         = 64'h2000_0000;
  localparam logic [31:0] ONE_Q30         = 32'h4000_0000;
  localparam int unsigned TAYLOR_LAST     = 13;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_SQRT,
    ST_TMUL,
    ST_TCHK,
    ST_T2MUL,
    ST_T2RND,
    ST_FTMUL,
    ST_FTRND,
    ST_XMUL,
    ST_XRND,
    ST_YMUL,
    ST_YRND,
    ST_ZMUL,
    ST_ZRND,
    ST_TMMUL,
    ST_TMRND,
    ST_DMUL,
    ST_TACC,
    ST_SHIFT,
    ST_KMUL,
    ST_KRND,
    ST_OMUL,
    ST_ORND,
    ST_OUT
  } state_t;

endpackage

### src/matern_covariance_eval_unit.sv
// ----------------------------------------------------------------------------
// matern_covariance_eval_unit: Matern covariance of a point pair
// Accumulates squared coordinate differences and, on the last coordinate,
// evaluates the selected Matern kernel scaled by the signal variance.
// ----------------------------------------------------------------------------
// One coordinate item is taken at a time. A coordinate that is not marked last
// is squared on the shared multiplier, then added with saturation. The last
// coordinate runs a bit-pair square root, a handful of multiply and round
// steps on the one 32x32 multiplier, and a Taylor series for the exponential
// with terms up to index 13, the division by the term index done as a
// multiply by its reciprocal. A far point pair or the unused selector skips
// the evaluation, and an exponential that underflows skips the series.
// A result sits in an output register, so the block may stall only in its
// final step while a previous result has not been taken.
module matern_covariance_eval_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] coord_a,
  input  logic signed [15:0] coord_b,
  input  logic               last_coord,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        kernel_value
);

  mce_pkg::state_t state, state_next;

  logic [1:0]  kernel_kind;
  logic [23:0] inv_length_scale;
  logic [23:0] var_scale;

  logic [40:0] distance_sum;
  logic [15:0] dabs;
  logic        last_q;
  logic [49:0] src;
  logic [26:0] rem;
  logic [24:0] root;
  logic [4:0]  cnt;
  logic [21:0] t;
  logic [27:0] t2;
  logic [28:0] ft;
  logic [23:0] x;
  logic [29:0] p;
  logic [4:0]  n;
  logic [29:0] g;
  logic [29:0] z;
  logic [30:0] term;
  logic [30:0] num;
  logic [3:0]  k_idx;
  logic [31:0] tsum;
  logic [30:0] e;
  logic [30:0] kv;
  logic [23:0] res;
  logic [63:0] prod;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r16, prod_r30;
  logic        in_accept, out_load;

  // Reciprocal of the term index: extra shift beyond 31 and multiplier, so
  // that (num * m) >> (31 + shift) is the exact quotient of any 31-bit num
  function automatic logic [34:0] recip_entry(input logic [3:0] k);
    logic [34:0] ent;
    unique case (k)
      4'd1:    ent = {3'd0, 32'd2147483648};
      4'd2:    ent = {3'd1, 32'd2147483648};
      4'd3:    ent = {3'd2, 32'd2863311531};
      4'd4:    ent = {3'd2, 32'd2147483648};
      4'd5:    ent = {3'd3, 32'd3435973837};
      4'd6:    ent = {3'd3, 32'd2863311531};
      4'd7:    ent = {3'd3, 32'd2454267027};
      4'd8:    ent = {3'd3, 32'd2147483648};
      4'd9:    ent = {3'd4, 32'd3817748708};
      4'd10:   ent = {3'd4, 32'd3435973837};
      4'd11:   ent = {3'd4, 32'd3123612579};
      4'd12:   ent = {3'd4, 32'd2863311531};
      4'd13:   ent = {3'd4, 32'd2643056798};
      default: ent = '0;
    endcase
    return ent;
  endfunction

  // Input side difference
  logic signed [16:0] diff;
  assign diff = {coord_a[15], coord_a} - {coord_b[15], coord_b};

  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == mce_pkg::ST_OUT) && (!out_valid || !out_stall);
  assign prod_r16  = prod + mce_pkg::RND_Q16;
  assign prod_r30  = prod + mce_pkg::RND_Q30;

  // Reciprocal of the current term index
  logic [34:0] recip;
  assign recip = recip_entry(k_idx);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_kind      <= mce_pkg::KIND_HALF;
      inv_length_scale <= 24'd65536;
      var_scale        <= 24'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mce_pkg::REG_KERNEL_KIND: kernel_kind      <= cfg_data[1:0];
        mce_pkg::REG_INV_LENGTH:  inv_length_scale <= cfg_data;
        mce_pkg::REG_SIGNAL_VAR:  var_scale        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      mce_pkg::ST_SQ: begin
        mul_a = 32'(dabs);
        mul_b = 32'(dabs);
      end
      mce_pkg::ST_TMUL: begin
        mul_a = 32'(root);
        mul_b = 32'(inv_length_scale);
      end
      mce_pkg::ST_T2MUL: begin
        mul_a = 32'(t);
        mul_b = 32'(t);
      end
      mce_pkg::ST_FTMUL: begin
        mul_a = 32'(t2);
        mul_b = mce_pkg::FIVE_THIRDS_Q16;
      end
      mce_pkg::ST_XMUL: begin
        mul_a = 32'(t);
        mul_b = (kernel_kind == mce_pkg::KIND_FIVE_HALVES) ?
                mce_pkg::SQRT5_Q16 : mce_pkg::SQRT3_Q16;
      end
      mce_pkg::ST_YMUL: begin
        mul_a = 32'(x);
        mul_b = mce_pkg::LOG2E_Q30;
      end
      mce_pkg::ST_ZMUL: begin
        mul_a = 32'(g);
        mul_b = mce_pkg::LN2_Q30;
      end
      mce_pkg::ST_TMMUL: begin
        mul_a = 32'(term);
        mul_b = 32'(z);
      end
      mce_pkg::ST_DMUL: begin
        mul_a = 32'(num);
        mul_b = recip[31:0];
      end
      mce_pkg::ST_KMUL: begin
        mul_a = 32'(p);
        mul_b = 32'(e);
      end
      mce_pkg::ST_OMUL: begin
        mul_a = 32'(kv);
        mul_b = 32'(var_scale);
      end
      default: ;
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = (state != mce_pkg::ST_IDLE);
    unique case (state)
      mce_pkg::ST_IDLE:  if (in_valid) begin
        state_next = mce_pkg::ST_SQ;
      end
      mce_pkg::ST_SQ:    state_next = mce_pkg::ST_ACC;
      mce_pkg::ST_ACC:   state_next = last_q ? mce_pkg::ST_SQRT : mce_pkg::ST_IDLE;
      mce_pkg::ST_SQRT:  if (cnt == 5'd0) begin
        state_next = mce_pkg::ST_TMUL;
      end
      mce_pkg::ST_TMUL:  state_next = mce_pkg::ST_TCHK;
      mce_pkg::ST_TCHK: begin
        if (kernel_kind > mce_pkg::KIND_FIVE_HALVES || (|prod_r16[63:38])) begin
          state_next = mce_pkg::ST_OUT;
        end else begin
          unique case (kernel_kind)
            mce_pkg::KIND_HALF:         state_next = mce_pkg::ST_YMUL;
            mce_pkg::KIND_THREE_HALVES: state_next = mce_pkg::ST_XMUL;
            default:                    state_next = mce_pkg::ST_T2MUL;
          endcase
        end
      end
      mce_pkg::ST_T2MUL: state_next = mce_pkg::ST_T2RND;
      mce_pkg::ST_T2RND: state_next = mce_pkg::ST_FTMUL;
      mce_pkg::ST_FTMUL: state_next = mce_pkg::ST_FTRND;
      mce_pkg::ST_FTRND: state_next = mce_pkg::ST_XMUL;
      mce_pkg::ST_XMUL:  state_next = mce_pkg::ST_XRND;
      mce_pkg::ST_XRND:  state_next = mce_pkg::ST_YMUL;
      mce_pkg::ST_YMUL:  state_next = mce_pkg::ST_YRND;
      mce_pkg::ST_YRND: begin
        if ((|prod_r16[63:51]) || (prod_r16[50:46] == 5'd31)) begin
          state_next = mce_pkg::ST_KMUL;
        end else begin
          state_next = mce_pkg::ST_ZMUL;
        end
      end
      mce_pkg::ST_ZMUL:  state_next = mce_pkg::ST_ZRND;
      mce_pkg::ST_ZRND:  state_next = mce_pkg::ST_TMMUL;
      mce_pkg::ST_TMMUL: state_next = mce_pkg::ST_TMRND;
      mce_pkg::ST_TMRND: state_next = mce_pkg::ST_DMUL;
      mce_pkg::ST_DMUL:  state_next = mce_pkg::ST_TACC;
      mce_pkg::ST_TACC: begin
        state_next = (k_idx == 4'(mce_pkg::TAYLOR_LAST)) ?
                     mce_pkg::ST_SHIFT : mce_pkg::ST_TMMUL;
      end
      mce_pkg::ST_SHIFT: state_next = mce_pkg::ST_KMUL;
      mce_pkg::ST_KMUL:  state_next = mce_pkg::ST_KRND;
      mce_pkg::ST_KRND:  state_next = mce_pkg::ST_OMUL;
      mce_pkg::ST_OMUL:  state_next = mce_pkg::ST_ORND;
      mce_pkg::ST_ORND:  state_next = mce_pkg::ST_OUT;
      mce_pkg::ST_OUT:   if (out_load) begin
        state_next = mce_pkg::ST_IDLE;
      end
      default:           state_next = mce_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mce_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulator: clear after the last coordinate of a pair
  logic [41:0] acc_sum;
  assign acc_sum = {1'b0, distance_sum} + {10'd0, prod[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sum <= '0;
    end else if (state == mce_pkg::ST_ACC) begin
      if (last_q) begin
        distance_sum <= '0;
      end else begin
        distance_sum <= acc_sum[41] ? '1 : acc_sum[40:0];
      end
    end
  end

  // Square root step: bring down two bits, try to subtract
  logic [28:0] sq_rem, sq_trial;
  assign sq_rem   = {rem, src[49:48]};
  assign sq_trial = {2'b00, root, 2'b01};

  // Quotient of the Taylor term: scale back the reciprocal product
  logic [63:0] quot_full;
  logic [30:0] quot;
  assign quot_full = prod >> (6'd31 + {3'd0, recip[34:32]});
  assign quot      = quot_full[30:0];

  // Taylor term after rounding, plus half the divisor
  logic [30:0] term_num;
  assign term_num = prod_r30[60:30] + 31'(k_idx >> 1);

  // Final scaling by 2^-n with rounding
  logic [31:0] shift_rnd, shift_val;
  assign shift_rnd = (n == 5'd0) ? 32'd0 : (32'd1 << (n - 5'd1));
  assign shift_val = (tsum + shift_rnd) >> n;

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      mce_pkg::ST_IDLE: begin
        dabs   <= diff[16] ? 16'(-diff) : diff[15:0];
        last_q <= last_coord;
      end
      mce_pkg::ST_ACC: begin
        src  <= {1'b0, (acc_sum[41] ? {41{1'b1}} : acc_sum[40:0]), 8'd0};
        rem  <= '0;
        root <= '0;
        cnt  <= 5'd24;
      end
      mce_pkg::ST_SQRT: begin
        if (sq_rem >= sq_trial) begin
          rem  <= 27'(sq_rem - sq_trial);
          root <= {root[23:0], 1'b1};
        end else begin
          rem  <= sq_rem[26:0];
          root <= {root[23:0], 1'b0};
        end
        src <= {src[47:0], 2'b00};
        cnt <= cnt - 5'd1;
      end
      mce_pkg::ST_TCHK: begin
        t   <= prod_r16[37:16];
        x   <= prod_r16[37:16];
        p   <= 30'd65536;
        res <= '0;
      end
      mce_pkg::ST_T2RND: t2 <= prod_r16[43:16];
      mce_pkg::ST_FTRND: ft <= prod_r16[44:16];
      mce_pkg::ST_XRND: begin
        x <= prod_r16[39:16];
        p <= 30'd65536 + 30'(prod_r16[39:16]) +
             ((kernel_kind == mce_pkg::KIND_FIVE_HALVES) ? 30'(ft) : 30'd0);
      end
      mce_pkg::ST_YRND: begin
        n <= prod_r16[50:46];
        g <= prod_r16[45:16];
        e <= '0;
      end
      mce_pkg::ST_ZRND: begin
        z     <= prod_r30[59:30];
        term  <= 31'(mce_pkg::ONE_Q30);
        tsum  <= mce_pkg::ONE_Q30;
        k_idx <= 4'd1;
      end
      mce_pkg::ST_TMRND: num <= term_num;
      mce_pkg::ST_TACC: begin
        term  <= quot;
        tsum  <= k_idx[0] ? (tsum - 32'(quot)) : (tsum + 32'(quot));
        k_idx <= k_idx + 4'd1;
      end
      mce_pkg::ST_SHIFT: e <= shift_val[30:0];
      mce_pkg::ST_KRND: begin
        kv <= (prod_r16[63:16] > 48'(mce_pkg::ONE_Q30)) ?
              31'(mce_pkg::ONE_Q30) : prod_r16[46:16];
      end
      mce_pkg::ST_ORND: begin
        res <= (|prod_r30[63:54]) ? 24'hFF_FFFF : prod_r30[53:30];
      end
      default: ;
    endcase
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kernel_value <= res;
    end
  end

  // Checks
  a_sum_clears: assert property (@(posedge clk) disable iff (rst)
    (state == mce_pkg::ST_ACC && last_q) |=> (distance_sum == '0))
    else $error("distance sum not cleared after last coordinate");

  a_rose_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == mce_pkg::ST_OUT))
    else $error("result raised outside the output step");

  a_taylor_range: assert property (@(posedge clk) disable iff (rst)
    (state == mce_pkg::ST_DMUL) |-> (k_idx != 4'd0 &&
      k_idx <= 4'(mce_pkg::TAYLOR_LAST)))
    else $error("Taylor divisor out of range");

endmodule
